### rtl/iq_linear_interp_resampler_assert.svh
// assertion macros for the i/q linear interpolation resampler
`ifndef IQ_LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define IQ_LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// same-cycle implication
`define IQLR_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IQLR_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/iqlr_pkg.sv
// shared constants and controller/datapath interface types
package iqlr_pkg;

	localparam int IQLR_SAMPLE_BITS = 24;
	localparam int IQLR_PHASE_FRAC_BITS = 32;

	// default step is the ratio of these two rates
	localparam longint unsigned IQLR_RATE_NUM = 64'd312500;
	localparam longint unsigned IQLR_RATE_DEN = 64'd384000;

	typedef struct packed {
		logic load;
		logic mul;
		logic emit;
		logic second;
		logic finish;
	} iqlr_cmd_t;

	typedef struct packed {
		logic phase_lt_one;
		logic last;
	} iqlr_sts_t;

endpackage

### rtl/iqlr_ctrl.sv
// controller state machine: sequences check, multiply, emit and hand-off per item
`include "iq_linear_interp_resampler_assert.svh"

module iqlr_ctrl
	import iqlr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  iqlr_sts_t sts,
	output iqlr_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_EMIT,
		S_OUT
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   valid_q;
	logic   second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			stall_q  <= 1'b0;
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !stall_q) begin
						state_q  <= S_CHECK;
						stall_q  <= 1'b1;
						second_q <= 1'b0;
					end
				end
				S_CHECK: begin
					if (sts.phase_lt_one) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				S_EMIT: begin
					state_q <= S_OUT;
					valid_q <= 1'b1;
				end
				S_OUT: begin
					if (!out_stall) begin
						valid_q <= 1'b0;
						if (sts.last) begin
							state_q <= S_IDLE;
							stall_q <= 1'b0;
						end else begin
							state_q  <= S_CHECK;
							second_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && in_valid && !stall_q;
		cmd.mul    = (state_q == S_CHECK) && sts.phase_lt_one;
		cmd.emit   = (state_q == S_EMIT);
		cmd.second = second_q;
		cmd.finish = ((state_q == S_CHECK) && !sts.phase_lt_one) ||
		             ((state_q == S_OUT) && !out_stall && sts.last);
	end

	assign in_stall  = stall_q;
	assign out_valid = valid_q;

	`IQLR_ASSERT_NOW(a_valid_blocks_input, clk, arst_n, valid_q, stall_q, "item offered on output while input open")
	`IQLR_ASSERT_NEXT(a_accept_closes, clk, arst_n, in_valid && !stall_q, stall_q && !valid_q && (state_q == S_CHECK), "input accept did not close the input")
	`IQLR_ASSERT_NEXT(a_second_due, clk, arst_n, valid_q && !out_stall && !sts.last, (state_q == S_CHECK) && sts.phase_lt_one && second_q, "non-final item not followed by a second")

endmodule

### rtl/iqlr_datapath.sv
// datapath: step register, phase accumulator, sample history, interpolation multiply
`include "iq_linear_interp_resampler_assert.svh"

module iqlr_datapath
	import iqlr_pkg::*;
#(
	parameter int SAMPLE_BITS     = IQLR_SAMPLE_BITS,
	parameter int PHASE_FRAC_BITS = IQLR_PHASE_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [PHASE_FRAC_BITS:0]      phase_step,
	input  logic signed [SAMPLE_BITS-1:0] sample_i,
	input  logic signed [SAMPLE_BITS-1:0] sample_q,
	input  iqlr_cmd_t                     cmd,
	output iqlr_sts_t                     sts,
	output logic signed [SAMPLE_BITS-1:0] out_i,
	output logic signed [SAMPLE_BITS-1:0] out_q,
	output logic                          last
);

	localparam int SB    = SAMPLE_BITS;
	localparam int FB    = PHASE_FRAC_BITS;
	localparam int PW    = FB + 2;
	localparam int PRODW = SB + FB + 2;

	localparam logic [FB:0]   STEP_HALF  = {2'b01, {(FB - 1){1'b0}}};
	localparam logic [FB:0]   STEP_RESET =
		(FB + 1)'((IQLR_RATE_NUM << FB) / IQLR_RATE_DEN);
	localparam logic [PW-1:0] ONE_PHASE  = {2'b01, {FB{1'b0}}};

	logic [FB:0]             step_q;
	logic [PW-1:0]           phase_q;
	logic signed [SB-1:0]    prev_i_q;
	logic signed [SB-1:0]    prev_q_q;
	logic signed [SB-1:0]    cur_i_q;
	logic signed [SB-1:0]    cur_q_q;
	logic signed [PRODW-1:0] prod_i_s1;
	logic signed [PRODW-1:0] prod_q_s1;
	logic signed [SB-1:0]    out_i_q;
	logic signed [SB-1:0]    out_q_q;
	logic                    last_q;

	logic signed [SB:0]      diff_i;
	logic signed [SB:0]      diff_q;
	logic signed [PRODW-1:0] frac_s;
	logic signed [PRODW-1:0] prod_i_c;
	logic signed [PRODW-1:0] prod_q_c;
	logic signed [PRODW-1:0] sh_i;
	logic signed [PRODW-1:0] sh_q;
	logic signed [SB+1:0]    interp_i;
	logic signed [SB+1:0]    interp_q;
	logic [PW-1:0]           phase_next;
	logic [FB:0]             step_w;

	assign step_w = (phase_step[FB:FB-1] == 2'b00) ? STEP_HALF : phase_step;

	assign diff_i = $signed({cur_i_q[SB-1], cur_i_q}) - $signed({prev_i_q[SB-1], prev_i_q});
	assign diff_q = $signed({cur_q_q[SB-1], cur_q_q}) - $signed({prev_q_q[SB-1], prev_q_q});
	assign frac_s = $signed({{(PRODW - FB){1'b0}}, phase_q[FB-1:0]});

	assign prod_i_c = $signed({{(PRODW - SB - 1){diff_i[SB]}}, diff_i}) * frac_s;
	assign prod_q_c = $signed({{(PRODW - SB - 1){diff_q[SB]}}, diff_q}) * frac_s;

	// floor of the product scaled down by the fraction width
	assign sh_i = prod_i_s1 >>> FB;
	assign sh_q = prod_q_s1 >>> FB;

	assign interp_i = $signed({{2{prev_i_q[SB-1]}}, prev_i_q}) + $signed(sh_i[SB+1:0]);
	assign interp_q = $signed({{2{prev_q_q[SB-1]}}, prev_q_q}) + $signed(sh_q[SB+1:0]);

	assign phase_next = phase_q + {1'b0, step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_RESET;
			phase_q  <= '0;
			prev_i_q <= '0;
			prev_q_q <= '0;
		end else begin
			if (cfg_we) begin
				step_q <= step_w;
			end
			if (cmd.emit) begin
				phase_q <= phase_next;
			end else if (cmd.finish) begin
				phase_q  <= phase_q - ONE_PHASE;
				prev_i_q <= cur_i_q;
				prev_q_q <= cur_q_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_i_q <= sample_i;
			cur_q_q <= sample_q;
		end
		if (cmd.mul) begin
			prod_i_s1 <= prod_i_c;
			prod_q_s1 <= prod_q_c;
		end
		if (cmd.emit) begin
			out_i_q <= interp_i[SB-1:0];
			out_q_q <= interp_q[SB-1:0];
			last_q  <= cmd.second || (phase_next[PW-1:FB] != 2'b00);
		end
	end

	assign sts.phase_lt_one = (phase_q[PW-1:FB] == 2'b00);
	assign sts.last         = last_q;

	assign out_i = out_i_q;
	assign out_q = out_q_q;
	assign last  = last_q;

	`IQLR_ASSERT_NOW(a_step_floor, clk, arst_n, 1'b1, step_q[FB:FB-1] != 2'b00, "phase step below one half")
	`IQLR_ASSERT_NEXT(a_second_is_last, clk, arst_n, cmd.emit && cmd.second, last_q, "second item of an input not marked last")

endmodule

### rtl/iq_linear_interp_resampler.sv
// top level of the i/q linear interpolation fractional resampler
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  sample_i, sample_q
//  out      source     out_valid/out_stall  out_i, out_q, last
//  cfg      sink       cfg_we               phase_step
//
// an item that gives no output goes from accept through the check state back to idle, where a new item can be accepted
// an item that gives n outputs (1 or 2) passes, per output, through check (with multiply), emit and out
// the phase check in the check state decides whether an output is due; the multiply is registered there for emit
// out_stall holds an offered item in the out state until it is taken
// arst_n clears phase, previous pair and step (to its default) at once; no clearing pass
module iq_linear_interp_resampler
	import iqlr_pkg::*;
#(
	parameter int SAMPLE_BITS     = IQLR_SAMPLE_BITS,
	parameter int PHASE_FRAC_BITS = IQLR_PHASE_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_i,
	input  logic signed [SAMPLE_BITS-1:0] sample_q,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_i,
	output logic signed [SAMPLE_BITS-1:0] out_q,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [PHASE_FRAC_BITS:0]      phase_step
);

	iqlr_cmd_t cmd;
	iqlr_sts_t sts;

	iqlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	iqlr_datapath #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.phase_step (phase_step),
		.sample_i   (sample_i),
		.sample_q   (sample_q),
		.cmd        (cmd),
		.sts        (sts),
		.out_i      (out_i),
		.out_q      (out_q),
		.last       (last)
	);

endmodule
